FILE: rtl/stack_mod_rotate_print_unit_assert.svh
// ----------------------------------------------------------------------------
// Stack unit assertion macros
// Shared forms for the concurrent checks on the stack unit's ports.
// ----------------------------------------------------------------------------
`ifndef STACK_MOD_ROTATE_PRINT_UNIT_ASSERT_SVH
`define STACK_MOD_ROTATE_PRINT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, idle during reset.
`define SMRP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, idle during reset.
`define SMRP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/smrp_pkg.sv
// ----------------------------------------------------------------------------
// Stack unit package
// Sizes, opcode and status codes, sequencer states and the port bundles
// shared by the stack unit's modules.
// ----------------------------------------------------------------------------
package smrp_pkg;

   // Sizes of the stack ring and its words.
   localparam int STACK_DEPTH = 32;
   localparam int WORD_W      = 32;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int SUM_W       = CNT_W + 1;
   localparam int STEP_W      = $clog2(WORD_W);
   localparam int CHAR_W      = 7;

   // A string print emits at most this many characters.
   localparam int MAX_RESULTS = 32;
   localparam int NCH_W       = $clog2(MAX_RESULTS + 1);

   // Character ranges.
   localparam logic signed [WORD_W-1:0] CHAR_LOW  = 32;
   localparam logic signed [WORD_W-1:0] CHAR_HIGH = 126;
   localparam logic signed [WORD_W-1:0] STR_LOW   = 1;
   localparam logic signed [WORD_W-1:0] STR_HIGH  = 127;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_MOD   = 3'd1,
      OP_PCHAR = 3'd2,
      OP_PSTR  = 3'd3,
      OP_ROTL  = 3'd4,
      OP_ROTR  = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_SHORT   = 3'd1,
      STAT_DIVZERO = 3'd2,
      STAT_EMPTY   = 3'd3,
      STAT_RANGE   = 3'd4,
      STAT_FULL    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_TOP,
      S_SEC,
      S_DIV,
      S_PSTR,
      S_PEND
   } state_type;

   // Memory write and read requests.
   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
   } mem_rd_type;

   // Remainder unit request and response.
   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] remainder;
   } div_rsp_type;

   // Folds a sum below twice the depth back into the ring.
   function automatic logic [PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] folded;
      folded = (sum >= SUM_W'(STACK_DEPTH)) ? sum - SUM_W'(STACK_DEPTH) : sum;
      return folded[PTR_W-1:0];
   endfunction

endpackage

FILE: rtl/stack_mod_rotate_print_unit.sv
// ----------------------------------------------------------------------------
// Bounded stack machine
// Ring-held stack of signed words with push, remainder, character print,
// string print and rotation, run by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (req_opcode, req_push_value) is taken at a rising edge
//   where start is high and busy is low. busy stays high until the last
//   result word of that command has been issued.
//   Each result word is shown on the rsp_ ports for one cycle, marked by
//   rsp_valid; rsp_last marks the final word of a command. The receiver
//   cannot stall, so every result word must be taken when shown.
//   Sequencer states per command, start to last result word:
//     push, rotates on a short stack, errors found at decode, pstr on an
//     empty stack: S_EXEC; pchar, rotl, rotr, division by zero: S_EXEC,
//     S_TOP; remainder: S_EXEC, S_TOP, S_SEC, then S_DIV for the
//     one-bit-per-cycle steps of the remainder unit; pstr: S_EXEC, S_PSTR,
//     S_PEND, one character per cycle, set by the single memory read port.
//   Reset empties the stack at once; stack words need no clearing pass.
// ----------------------------------------------------------------------------
module stack_mod_rotate_print_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_opcode,
   input  logic signed [smrp_pkg::WORD_W-1:0] req_push_value,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_status,
   output logic                              rsp_has_char,
   output logic [smrp_pkg::CHAR_W-1:0]       rsp_char_out,
   output logic                              rsp_last
);
   import smrp_pkg::*;

   state_type          state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic [WORD_W-1:0]  value_ff, value_in;
   logic [PTR_W-1:0]   bottom_ff, bottom_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   depth_ff, depth_in;
   logic [NCH_W-1:0]   nchar_ff, nchar_in;
   logic               pend_ff, pend_in;
   logic [CHAR_W-1:0]  pchar_ff, pchar_in;
   logic [WORD_W-1:0]  divisor_ff, divisor_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_has_char_ff, rsp_has_char_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   mem_wr_type         mem_wr;
   mem_rd_type         mem_rd;
   logic [WORD_W-1:0]  mem_rdata;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               accept;
   logic [CNT_W-1:0]   rd_depth;
   logic               rd_bottom;
   logic [PTR_W-1:0]   slot_rd;
   logic [PTR_W-1:0]   slot_sec;
   logic [PTR_W-1:0]   slot_push;
   logic [PTR_W-1:0]   bottom_dec;
   logic [PTR_W-1:0]   bottom_inc;
   logic               is_full;
   logic               is_empty;
   logic               has_two;
   logic               is_print;
   logic               is_strc;
   logic [CNT_W-1:0]   depth_next;
   logic [NCH_W-1:0]   nchar_next;
   logic               str_more;

   // Shared units.
   smrp_stack_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (mem_rdata)
   );

   smrp_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Ring addresses and stack conditions.
   assign slot_rd    = ring_wrap(SUM_W'(bottom_ff) +
                                 SUM_W'(count_ff - CNT_W'(1) - rd_depth));
   assign slot_sec   = ring_wrap(SUM_W'(bottom_ff) + SUM_W'(count_ff - CNT_W'(2)));
   assign slot_push  = ring_wrap(SUM_W'(bottom_ff) + SUM_W'(count_ff));
   assign bottom_dec = (bottom_ff == '0) ? PTR_W'(STACK_DEPTH - 1)
                                         : bottom_ff - PTR_W'(1);
   assign bottom_inc = (bottom_ff == PTR_W'(STACK_DEPTH - 1)) ? '0
                                                             : bottom_ff + PTR_W'(1);
   assign is_full    = (count_ff == CNT_W'(STACK_DEPTH));
   assign is_empty   = (count_ff == '0);
   assign has_two    = (count_ff >= CNT_W'(2));
   assign is_print   = ($signed(mem_rdata) >= CHAR_LOW) && ($signed(mem_rdata) <= CHAR_HIGH);
   assign is_strc    = ($signed(mem_rdata) >= STR_LOW) && ($signed(mem_rdata) <= STR_HIGH);
   assign depth_next = depth_ff + CNT_W'(1);
   assign nchar_next = nchar_ff + NCH_W'(1);
   assign str_more   = (depth_next < count_ff) && (nchar_next < NCH_W'(MAX_RESULTS));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_MOD:   state_in = has_two ? S_TOP : S_IDLE;
               OP_PCHAR: state_in = is_empty ? S_IDLE : S_TOP;
               OP_PSTR:  state_in = is_empty ? S_IDLE : S_PSTR;
               OP_ROTL,
               OP_ROTR:  state_in = has_two ? S_TOP : S_IDLE;
               default:  state_in = S_IDLE;
            endcase
         end
         S_TOP: begin
            state_in = (op_ff == OP_MOD && mem_rdata != '0) ? S_SEC : S_IDLE;
         end
         S_SEC: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_IDLE;
            end
         end
         S_PSTR: begin
            priority if (!is_strc) begin
               state_in = S_IDLE;
            end else if (!str_more) begin
               state_in = S_PEND;
            end
         end
         S_PEND: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath controls, stack updates and result words.
   always_comb begin
      op_in           = op_ff;
      value_in        = value_ff;
      bottom_in       = bottom_ff;
      count_in        = count_ff;
      depth_in        = depth_ff;
      nchar_in        = nchar_ff;
      pend_in         = pend_ff;
      pchar_in        = pchar_ff;
      divisor_in      = divisor_ff;
      rd_depth        = depth_ff;
      rd_bottom       = 1'b0;
      mem_rd.en       = 1'b0;
      mem_wr.en       = 1'b0;
      mem_wr.addr     = slot_push;
      mem_wr.data     = value_ff;
      div_req.start   = 1'b0;
      div_req.dividend = mem_rdata;
      div_req.divisor = divisor_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = STAT_OK;
      rsp_has_char_in = 1'b0;
      rsp_char_in     = '0;
      rsp_last_in     = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               value_in = req_push_value;
               depth_in = '0;
               nchar_in = '0;
               pend_in  = 1'b0;
            end
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_PUSH: begin
                  rsp_valid_in = 1'b1;
                  if (is_full) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     mem_wr.en = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                  end
               end
               OP_MOD: begin
                  if (has_two) begin
                     mem_rd.en = 1'b1;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_SHORT;
                  end
               end
               OP_PCHAR: begin
                  if (is_empty) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_EMPTY;
                  end else begin
                     mem_rd.en = 1'b1;
                  end
               end
               OP_PSTR: begin
                  if (is_empty) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     mem_rd.en = 1'b1;
                  end
               end
               OP_ROTL: begin
                  if (has_two) begin
                     mem_rd.en = 1'b1;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
               OP_ROTR: begin
                  if (has_two) begin
                     mem_rd.en = 1'b1;
                     rd_bottom = 1'b1;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         S_TOP: begin
            unique case (op_ff)
               OP_MOD: begin
                  // The top word is the divisor; fetch the second word next.
                  divisor_in = mem_rdata;
                  mem_rd.en  = 1'b1;
                  rd_depth   = CNT_W'(1);
                  if (mem_rdata == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_DIVZERO;
                  end
               end
               OP_PCHAR: begin
                  rsp_valid_in = 1'b1;
                  if (is_print) begin
                     rsp_has_char_in = 1'b1;
                     rsp_char_in     = mem_rdata[CHAR_W-1:0];
                  end else begin
                     rsp_status_in = STAT_RANGE;
                  end
               end
               OP_ROTL: begin
                  // Top word moves below the bottom.
                  rsp_valid_in = 1'b1;
                  bottom_in    = bottom_dec;
                  mem_wr.en    = 1'b1;
                  mem_wr.addr  = bottom_dec;
                  mem_wr.data  = mem_rdata;
               end
               OP_ROTR: begin
                  // Bottom word moves above the top.
                  rsp_valid_in = 1'b1;
                  bottom_in    = bottom_inc;
                  mem_wr.en    = 1'b1;
                  mem_wr.addr  = slot_push;
                  mem_wr.data  = mem_rdata;
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         S_SEC: begin
            div_req.start = 1'b1;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               mem_wr.en    = 1'b1;
               mem_wr.addr  = slot_sec;
               mem_wr.data  = div_rsp.remainder;
               count_in     = count_ff - CNT_W'(1);
               rsp_valid_in = 1'b1;
            end
         end
         S_PSTR: begin
            // A character is held back in pchar_ff so the last one can be marked.
            if (is_strc) begin
               rsp_valid_in    = pend_ff;
               rsp_has_char_in = 1'b1;
               rsp_char_in     = pchar_ff;
               rsp_last_in     = 1'b0;
               pend_in         = 1'b1;
               pchar_in        = mem_rdata[CHAR_W-1:0];
               depth_in        = depth_next;
               nchar_in        = nchar_next;
               if (str_more) begin
                  mem_rd.en = 1'b1;
                  rd_depth  = depth_next;
               end
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_has_char_in = pend_ff;
               rsp_char_in     = pend_ff ? pchar_ff : '0;
            end
         end
         S_PEND: begin
            rsp_valid_in    = 1'b1;
            rsp_has_char_in = 1'b1;
            rsp_char_in     = pchar_ff;
         end
         default: begin
         end
      endcase
      mem_rd.addr = rd_bottom ? bottom_ff : slot_rd;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bottom_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bottom_ff    <= bottom_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command and result payload registers.
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      value_ff        <= value_in;
      depth_ff        <= depth_in;
      nchar_ff        <= nchar_in;
      pend_ff         <= pend_in;
      pchar_ff        <= pchar_in;
      divisor_ff      <= divisor_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_has_char_ff <= rsp_has_char_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_has_char = rsp_has_char_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

FILE: rtl/smrp_stack_mem.sv
// ----------------------------------------------------------------------------
// Stack ring memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smrp_stack_mem (
   input  logic                        clock,
   input  smrp_pkg::mem_wr_type        wr,
   input  smrp_pkg::mem_rd_type        rd,
   output logic [smrp_pkg::WORD_W-1:0] rd_data
);
   import smrp_pkg::*;

   logic [WORD_W-1:0] store_ff [STACK_DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr] <= wr.data;
      end
   end

   // Read port, data registered.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= store_ff[rd.addr];
      end
   end

endmodule

FILE: rtl/smrp_divider.sv
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Signed truncating remainder by restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module smrp_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  smrp_pkg::div_req_type req,
   output smrp_pkg::div_rsp_type rsp
);
   import smrp_pkg::*;

   logic              run_ff,  run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WORD_W-1:0] rem_ff,  rem_in;
   logic [WORD_W-1:0] quo_ff,  quo_in;
   logic [WORD_W-1:0] dvs_ff,  dvs_in;
   logic              neg_ff,  neg_in;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   trial;

   // One restoring step: shift in the next dividend bit and try a subtract.
   assign shifted = {rem_ff, quo_ff[WORD_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (req.start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = req.dividend[WORD_W-1] ? ~req.dividend + WORD_W'(1) : req.dividend;
         dvs_in  = req.divisor[WORD_W-1] ? ~req.divisor + WORD_W'(1) : req.divisor;
         neg_in  = req.dividend[WORD_W-1];
      end else if (run_ff) begin
         rem_in  = trial[WORD_W] ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];
         quo_in  = {quo_ff[WORD_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(WORD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   // The remainder takes the sign of the dividend.
   assign rsp.done      = done_ff;
   assign rsp.remainder = neg_ff ? ~rem_ff + WORD_W'(1) : rem_ff;

endmodule

FILE: rtl/smrp_checker.sv
// ----------------------------------------------------------------------------
// Stack unit port checker
// Concurrent checks on the stack unit's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "stack_mod_rotate_print_unit_assert.svh"

module smrp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [2:0]                  rsp_status,
   input logic                        rsp_has_char,
   input logic [smrp_pkg::CHAR_W-1:0] rsp_char_out,
   input logic                        rsp_last
);
   import smrp_pkg::*;

   // A word without a character always closes its command.
   `SMRP_ASSERT_IMP(a_nochar_last, rsp_valid && !rsp_has_char, rsp_last, "non-char word not last")
   // Character words only come from successful prints.
   `SMRP_ASSERT_IMP(a_char_ok, rsp_valid && rsp_has_char, rsp_status == STAT_OK, "char with error")
   // A printed character is never zero.
   `SMRP_ASSERT_IMP(a_char_nz, rsp_valid && rsp_has_char, rsp_char_out != '0, "zero char emitted")
   // A taken command keeps the unit busy.
   `SMRP_ASSERT_NXT(a_busy, start && !busy, busy, "busy not raised after start")
   // The last word of a command is not followed at once by another word.
   `SMRP_ASSERT_NXT(a_gap, rsp_valid && rsp_last, !rsp_valid, "word right after last word")

endmodule

bind stack_mod_rotate_print_unit smrp_checker u_smrp_checker (.*);
